// File: rtl/art_pkg.sv
package art_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxBits    = $clog2(TableDepth);
  localparam int unsigned CntBits    = $clog2(TableDepth + 1);
  localparam int unsigned PortBits   = 4;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_ACCESS = 2'd2,
    MODE_NONE   = 2'd3
  } item_mode_e;

  typedef enum logic [1:0] {
    MAP_BLOCK = 2'd0,
    MAP_PASS  = 2'd1,
    MAP_XLATE = 2'd2,
    MAP_ALT   = 2'd3
  } map_mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOMAP = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_PIECE,
    S_EMIT
  } ctl_state_e;

  // one table entry as stored
  typedef struct packed {
    logic [63:0]         base;
    logic [63:0]         lim;
    logic [63:0]         obase;
    logic [PortBits-1:0] port;
  } region_t;

  // table port between control and memory
  typedef struct packed {
    logic               we;
    logic [IdxBits-1:0] waddr;
    region_t            wdata;
    logic [IdxBits-1:0] raddr;
  } tbl_req_t;

endpackage

// File: rtl/address_range_translator_core.sv
// Address range translator. Items enter on start while busy is low; each result
// appears for one cycle with result_valid_o and cannot be stalled. Clear, append
// to an empty or a full table, block and passthrough items answer in the cycle
// after the beat is accepted and never raise busy; ignored items give no result
// and never raise busy. Append walks the sorted table down from the top, moving
// each entry with a larger base up one slot through the registered-read table
// memory (S_INS_RD, S_INS_CHK). An access searches the table by binary search,
// at most 5 probes per piece; it emits one result per piece, at most 17 in all.
module address_range_translator_core
  import art_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode_i,
  input  logic [63:0]         addr_i,
  input  logic [63:0]         entry_length_i,
  input  logic [63:0]         out_base_i,
  input  logic [PortBits-1:0] entry_target_i,
  input  logic [1:0]          access_size_log2_i,
  input  logic [15:0]         access_count_i,
  input  logic                atomic_i,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data,
  output logic                result_valid_o,
  output logic [1:0]          status_o,
  output logic [63:0]         sub_addr_o,
  output logic [15:0]         sub_count_o,
  output logic [18:0]         buf_offset_o,
  output logic [PortBits-1:0] target_port_o,
  output logic                to_next_o,
  output logic                is_last_o
);

  ctl_state_e state_q, state_d;
  logic [1:0] map_q;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [CntBits-1:0] lo_q, lo_d, hi_q, hi_d, pos_q, pos_d;
  logic [63:0] addr_q, addr_d;
  logic [18:0] len_q, len_d, off_q, off_d;
  logic [1:0] lg_q, lg_d;
  logic [15:0] acnt_q, acnt_d;
  logic atom_q, atom_d;
  logic [4:0] pieces_q, pieces_d;
  region_t ins_q, ins_d;
  tbl_req_t req;
  region_t rd;

  logic rv_d, rv_q, nx_d, nx_q, last_d, last_q;
  logic [1:0] st_d, st_q;
  logic [63:0] sa_d, sa_q;
  logic [15:0] sc_d, sc_q;
  logic [18:0] bo_d, bo_q;
  logic [PortBits-1:0] tp_d, tp_q;

  logic [CntBits-1:0] mid;
  logic [63:0] delta, avail_full;
  logic [18:0] avail;

  art_table u_table (.clk_i(clk_i), .req_i(req), .rdata_o(rd));

  assign busy = (state_q != S_IDLE);
  assign cfg_ready = (state_q == S_IDLE);
  assign mid = CntBits'((CntBits'(lo_q) + CntBits'(hi_q)) >> 1);
  assign delta = addr_q - rd.base;
  // bytes left in the region from the current address
  assign avail_full = rd.lim - addr_q;
  assign avail = (avail_full > 64'(len_q)) ? len_q : avail_full[18:0];

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= MAP_BLOCK;
    end else if (cfg_valid && cfg_ready) begin
      map_q <= cfg_data;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; pos_q <= pos_d;
    addr_q <= addr_d; len_q <= len_d; off_q <= off_d;
    lg_q <= lg_d; acnt_q <= acnt_d; atom_q <= atom_d;
    pieces_q <= pieces_d; ins_q <= ins_d;
    st_q <= st_d; sa_q <= sa_d; sc_q <= sc_d; bo_q <= bo_d;
    tp_q <= tp_d; nx_q <= nx_d; last_q <= last_d;
  end

  // sequencer
  always_comb begin
    state_d = state_q; cnt_d = cnt_q;
    lo_d = lo_q; hi_d = hi_q; pos_d = pos_q;
    addr_d = addr_q; len_d = len_q; off_d = off_q;
    lg_d = lg_q; acnt_d = acnt_q; atom_d = atom_q;
    pieces_d = pieces_q; ins_d = ins_q;
    rv_d = 1'b0; st_d = ST_OK; sa_d = '0; sc_d = '0; bo_d = '0;
    tp_d = '0; nx_d = 1'b0; last_d = 1'b1;
    req = '0;
    req.raddr = mid[IdxBits-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          addr_d = addr_i; lg_d = access_size_log2_i; acnt_d = access_count_i;
          atom_d = atomic_i; off_d = '0; pieces_d = '0;
          len_d = 19'(access_count_i) << access_size_log2_i;
          ins_d.base = addr_i; ins_d.lim = addr_i + entry_length_i;
          ins_d.obase = out_base_i; ins_d.port = entry_target_i;
          unique case (mode_i)
            MODE_CLEAR: begin
              cnt_d = '0; rv_d = 1'b1;
            end
            MODE_APPEND: begin
              if (cnt_q >= CntBits'(TableDepth)) begin
                rv_d = 1'b1; st_d = ST_FULL;
              end else if (cnt_q == '0) begin
                req.we = 1'b1; req.waddr = '0;
                req.wdata = ins_d; cnt_d = cnt_q + 1'b1; rv_d = 1'b1;
              end else begin
                pos_d = cnt_q;
                req.raddr = IdxBits'(cnt_q - 1'b1);
                state_d = S_INS_RD;
              end
            end
            MODE_ACCESS: begin
              if (map_q == MAP_BLOCK) begin
                rv_d = 1'b1; st_d = ST_NOMAP;
              end else if (map_q == MAP_PASS) begin
                rv_d = 1'b1; sa_d = addr_i; sc_d = access_count_i; nx_d = 1'b1;
              end else if (atomic_i || access_count_i != '0) begin
                state_d = S_PIECE;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS_RD: begin
        // keep entry pos-1 on the read port
        req.raddr = IdxBits'(pos_q - 1'b1);
        state_d = S_INS_CHK;
      end
      S_INS_CHK: begin
        // rd holds entry pos-1
        req.we = 1'b1;
        if (rd.base > ins_q.base) begin
          req.waddr = pos_q[IdxBits-1:0]; req.wdata = rd;
          pos_d = pos_q - 1'b1;
          if (pos_q == CntBits'(1)) begin
            state_d = S_EMIT;
          end else begin
            req.raddr = IdxBits'(pos_q - 2'd2);
            state_d = S_INS_RD;
          end
        end else begin
          req.waddr = pos_q[IdxBits-1:0]; req.wdata = ins_q;
          cnt_d = cnt_q + 1'b1; rv_d = 1'b1; state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        req.we = 1'b1; req.waddr = '0; req.wdata = ins_q;
        cnt_d = cnt_q + 1'b1; rv_d = 1'b1; state_d = S_IDLE;
      end
      S_PIECE: begin
        // start a lookup for addr_q
        lo_d = '0; hi_d = cnt_q;
        if (cnt_q == '0 || pieces_q >= 5'(TableDepth)) begin
          rv_d = 1'b1; st_d = ST_NOMAP; state_d = S_IDLE;
        end else begin
          req.raddr = IdxBits'(cnt_q >> 1);
          state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: state_d = S_SRCH_CHK;
      S_SRCH_CHK: begin
        if (rd.base > addr_q) begin
          hi_d = mid;
          if (lo_q == mid) begin
            rv_d = 1'b1; st_d = ST_NOMAP; state_d = S_IDLE;
          end else begin
            req.raddr = IdxBits'((CntBits'(lo_q) + CntBits'(mid)) >> 1);
            state_d = S_SRCH_RD;
          end
        end else if (rd.lim > addr_q) begin
          rv_d = 1'b1; tp_d = rd.port; sa_d = rd.obase + delta;
          if (atom_q) begin
            sc_d = acnt_q; state_d = S_IDLE;
          end else begin
            sc_d = 16'(avail >> lg_q); bo_d = off_q;
            last_d = (avail == len_q);
            len_d = len_q - avail; off_d = off_q + avail;
            addr_d = addr_q + 64'(avail); pieces_d = pieces_q + 1'b1;
            state_d = (avail == len_q) ? S_IDLE : S_PIECE;
          end
        end else if (lo_q == mid) begin
          rv_d = 1'b1; st_d = ST_NOMAP; state_d = S_IDLE;
        end else begin
          lo_d = mid;
          req.raddr = IdxBits'((CntBits'(mid) + CntBits'(hi_q)) >> 1);
          state_d = S_SRCH_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign result_valid_o = rv_q;
  assign status_o = st_q;
  assign sub_addr_o = sa_q;
  assign sub_count_o = sc_q;
  assign buf_offset_o = bo_q;
  assign target_port_o = tp_q;
  assign to_next_o = nx_q;
  assign is_last_o = last_q;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(TableDepth)) else $error("table count overflow");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && state_q == S_PIECE) |-> !rv_q || !is_last_o)
    else $error("last beat while pieces remain");
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_d && last_d) |=> state_q == S_IDLE) else $error("last beat left busy");
`endif

endmodule

// File: rtl/art_table.sv
module art_table
  import art_pkg::*;
(
  input  logic     clk_i,
  input  tbl_req_t req_i,
  output region_t  rdata_o
);

  region_t mem_q [TableDepth];

  // single write, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule
